// File: rtl/mi_pkg.sv
// Package with the shared word width default for the modular inverse block.
package mi_pkg;

	localparam int DEF_WORD_BITS = 31;

endpackage

// File: rtl/mi_divstep.sv
// Shared restoring divider that also builds the product of the quotient and a coefficient.
module mi_divstep #(
	parameter int WORD_BITS = mi_pkg::DEF_WORD_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        go,
	input  logic [WORD_BITS-1:0]        dividend,
	input  logic [WORD_BITS-1:0]        divisor,
	input  logic signed [WORD_BITS+1:0] coef,
	output logic                        done,
	output logic [WORD_BITS-1:0]        remainder,
	output logic signed [WORD_BITS+1:0] product
);

	localparam int CW = $clog2(WORD_BITS);
	localparam logic [CW-1:0] LAST_CNT = CW'(WORD_BITS - 1);

	logic                        run_q;
	logic                        done_q;
	logic [CW-1:0]               cnt_q;
	logic [WORD_BITS-1:0]        dvd_q;
	logic [WORD_BITS-1:0]        dsr_q;
	logic [WORD_BITS-1:0]        rem_q;
	logic signed [WORD_BITS+1:0] coef_q;
	logic signed [WORD_BITS+1:0] prod_q;

	logic [WORD_BITS:0]          rem_sh;
	logic [WORD_BITS:0]          diff;
	logic                        ge;
	logic [WORD_BITS-1:0]        rem_nxt;
	logic signed [WORD_BITS+1:0] prod_nxt;

	// One quotient bit per cycle, most significant first; the product is
	// accumulated in the same Horner order as the quotient bits appear.
	always_comb begin
		rem_sh   = {rem_q, dvd_q[WORD_BITS-1]};
		diff     = rem_sh - {1'b0, dsr_q};
		ge       = ~diff[WORD_BITS];
		rem_nxt  = ge ? diff[WORD_BITS-1:0] : rem_sh[WORD_BITS-1:0];
		prod_nxt = (prod_q <<< 1) + (ge ? coef_q : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= LAST_CNT;
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			dvd_q  <= dividend;
			dsr_q  <= divisor;
			coef_q <= coef;
			rem_q  <= '0;
			prod_q <= '0;
		end else if (run_q) begin
			dvd_q  <= {dvd_q[WORD_BITS-2:0], 1'b0};
			rem_q  <= rem_nxt;
			prod_q <= prod_nxt;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;
	assign product   = prod_q;

endmodule

// File: rtl/modular_inverse.sv
// Top level of the modular inverse block: extended Euclid sequencer and final reduction.
//
//  channel  | handshake           | fields
//  ---------+---------------------+------------------
//  input    | start, busy         | value, modulus
//  result   | done (one cycle)    | inverse, exists
//
// Each Euclid round issues the shared divider from CHECK, waits in DIV for its
// done and moves the working registers in UPDATE; FIX1 and FIX2 then reduce the
// result, and a pair of 31-bit words needs at most about 46 rounds.
// busy rises after the accepted start beat and is low again in the result beat. The result
// is shown for one cycle with done high and cannot be stalled. Reset returns the
// sequencer to idle.
module modular_inverse #(
	parameter int WORD_BITS = mi_pkg::DEF_WORD_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [WORD_BITS-1:0] value,
	input  logic [WORD_BITS-1:0] modulus,
	output logic                 done,
	output logic [WORD_BITS-1:0] inverse,
	output logic                 exists
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_UPDATE,
		ST_FIX1,
		ST_FIX2
	} state_t;

	state_t                      state_q;
	logic                        done_q;
	logic                        exists_q;
	logic [WORD_BITS-1:0]        inverse_q;
	logic                        go_q;
	logic [WORD_BITS-1:0]        m_q;
	logic [WORD_BITS-1:0]        r_prev_q;
	logic [WORD_BITS-1:0]        r_cur_q;
	logic signed [WORD_BITS+1:0] s_prev_q;
	logic signed [WORD_BITS+1:0] s_cur_q;

	logic                        div_done;
	logic [WORD_BITS-1:0]        div_rem;
	logic signed [WORD_BITS+1:0] div_prod;
	logic signed [WORD_BITS+1:0] m_ext;

	assign m_ext = signed'({2'b00, m_q});

	mi_divstep #(
		.WORD_BITS(WORD_BITS)
	) u_divstep (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (go_q),
		.dividend (r_prev_q),
		.divisor  (r_cur_q),
		.coef     (s_cur_q),
		.done     (div_done),
		.remainder(div_rem),
		.product  (div_prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			done_q    <= 1'b0;
			go_q      <= 1'b0;
			exists_q  <= 1'b0;
			inverse_q <= '0;
		end else begin
			done_q <= 1'b0;
			go_q   <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (r_cur_q == '0) begin
						state_q <= ST_FIX1;
					end else begin
						go_q    <= 1'b1;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					state_q <= ST_CHECK;
				end
				ST_FIX1: begin
					// The gcd is left in r_prev; a zero modulus never has an inverse.
					exists_q <= (m_q != '0) && (r_prev_q == WORD_BITS'(1));
					state_q  <= ST_FIX2;
				end
				ST_FIX2: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
					if (exists_q) begin
						if ($unsigned(s_prev_q) >= $unsigned(m_ext)) begin
							inverse_q <= WORD_BITS'(s_prev_q - m_ext);
						end else begin
							inverse_q <= s_prev_q[WORD_BITS-1:0];
						end
					end else begin
						inverse_q <= '0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Euclid working registers; the coefficient is brought into 0..m in FIX1
	// and then below m in FIX2.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					m_q      <= modulus;
					r_prev_q <= value;
					r_cur_q  <= modulus;
					s_prev_q <= (WORD_BITS+2)'(1);
					s_cur_q  <= '0;
				end
			end
			ST_UPDATE: begin
				r_prev_q <= r_cur_q;
				r_cur_q  <= div_rem;
				s_prev_q <= s_cur_q;
				s_cur_q  <= s_prev_q - div_prod;
			end
			ST_FIX1: begin
				if (s_prev_q < 0) begin
					s_prev_q <= s_prev_q + m_ext;
				end
			end
			default: begin
			end
		endcase
	end

	assign busy    = (state_q != ST_IDLE);
	assign done    = done_q;
	assign inverse = inverse_q;
	assign exists  = exists_q;

endmodule

// File: verif/modular_inverse_checker.sv
// Checker that predicts each modular inverse result and compares it with the block's output.
`timescale 1ns / 100ps

module modular_inverse_checker #(
	parameter int WORD_BITS = mi_pkg::DEF_WORD_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 busy,
	input  logic [WORD_BITS-1:0] value,
	input  logic [WORD_BITS-1:0] modulus,
	input  logic                 done,
	input  logic [WORD_BITS-1:0] inverse,
	input  logic                 exists,
	output int                   errors,
	output int                   pending
);

	typedef struct packed {
		logic [WORD_BITS-1:0] inverse;
		logic                 exists;
	} inverse_beat_t;

	inverse_beat_t expected_inverses[$];

	int error_count   = 0;
	int pending_count = 0;

	assign errors  = error_count;
	assign pending = pending_count;

	// Extended Euclid on 64-bit wrapping coefficients, then reduction into 0 .. m-1.
	function automatic inverse_beat_t predict_inverse(logic [WORD_BITS-1:0] a,
			logic [WORD_BITS-1:0] m);
		logic [63:0]   r_old;
		logic [63:0]   r_new;
		logic [63:0]   s_old;
		logic [63:0]   s_new;
		logic [63:0]   quot;
		logic [63:0]   r_tmp;
		logic [63:0]   s_tmp;
		logic [63:0]   mag;
		logic [63:0]   m_wide;
		inverse_beat_t res;
		m_wide = 64'(m);
		r_old  = 64'(a);
		r_new  = m_wide;
		s_old  = 64'd1;
		s_new  = 64'd0;
		res    = '0;
		while (r_new != 64'd0) begin
			quot  = r_old / r_new;
			r_tmp = r_old - quot * r_new;
			s_tmp = s_old - quot * s_new;
			r_old = r_new;
			r_new = r_tmp;
			s_old = s_new;
			s_new = s_tmp;
		end
		if (m_wide != 64'd0 && r_old == 64'd1) begin
			res.exists = 1'b1;
			if (s_old[63]) begin
				mag = (64'd0 - s_old) % m_wide;
				res.inverse = (mag == 64'd0) ? '0 : WORD_BITS'(m_wide - mag);
			end else begin
				res.inverse = WORD_BITS'(s_old % m_wide);
			end
		end
		return res;
	endfunction

	always @(posedge clk) begin
		inverse_beat_t exp_beat;
		if (arst_n) begin
			if (done) begin
				if (expected_inverses.size() == 0) begin
					$error("result beat with no result pending: inverse %0d exists %0d",
						inverse, exists);
					error_count <= error_count + 1;
				end else begin
					exp_beat = expected_inverses.pop_front();
					if (inverse !== exp_beat.inverse || exists !== exp_beat.exists) begin
						error_count <= error_count + 1;
					end
					if (inverse !== exp_beat.inverse) begin
						$error("inverse: expected %0d, actual %0d", exp_beat.inverse, inverse);
					end
					if (exists !== exp_beat.exists) begin
						$error("exists: expected %0d, actual %0d", exp_beat.exists, exists);
					end
				end
			end
			if (start && !busy) begin
				expected_inverses.push_back(predict_inverse(value, modulus));
			end
			pending_count <= expected_inverses.size();
		end
	end

endmodule

// File: verif/modular_inverse_tb.sv
// Testbench top for the modular inverse block: stimulus, clock, reset and verdict.
`timescale 1ns / 100ps

module modular_inverse_tb;

	localparam int W          = mi_pkg::DEF_WORD_BITS;
	localparam int CYCLE_CAP  = 4000000;
	localparam int DRAIN_WAIT = 2048;
	localparam int RAND_ITEMS = 290;

	localparam logic [W-1:0] MAX_WORD = '1;
	localparam logic [W-1:0] FIB_HI   = W'(1836311903);
	localparam logic [W-1:0] FIB_LO   = W'(1134903170);

	logic         clk;
	logic         arst_n;
	logic         start;
	logic         busy;
	logic [W-1:0] value;
	logic [W-1:0] modulus;
	logic         done;
	logic [W-1:0] inverse;
	logic         exists;
	int           errors;
	int           pending;
	int           cycles = 0;

	modular_inverse #(.WORD_BITS(W)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.value(value),
		.modulus(modulus),
		.done(done),
		.inverse(inverse),
		.exists(exists)
	);

	modular_inverse_checker #(.WORD_BITS(W)) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.value(value),
		.modulus(modulus),
		.done(done),
		.inverse(inverse),
		.exists(exists),
		.errors(errors),
		.pending(pending)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_CAP) begin
			$display("modular_inverse: mismatch");
			$finish;
		end
	end

	// Called at a falling edge; returns at the falling edge after the beat is taken.
	task automatic send_pair(input logic [W-1:0] a, input logic [W-1:0] m);
		start   <= 1'b1;
		value   <= a;
		modulus <= m;
		do begin
			@(posedge clk);
		end while (busy);
		@(negedge clk);
	endtask

	task automatic hold_off(input int n);
		start <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	task automatic wait_drained;
		start <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	initial begin
		logic [W-1:0] a;
		logic [W-1:0] m;
		int           sent;
		int           burst;
		arst_n  = 1'b0;
		start   = 1'b0;
		value   = '0;
		modulus = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed corners: zero modulus, modulus one, zero value, value above modulus,
		// shared factors, all-ones words and the Fibonacci pair that needs the most rounds.
		send_pair('0, '0);
		send_pair(W'(1), '0);
		send_pair(MAX_WORD, '0);
		send_pair('0, W'(1));
		send_pair(MAX_WORD, W'(1));
		send_pair('0, W'(7));
		send_pair('0, MAX_WORD);
		send_pair(W'(3), W'(7));
		send_pair(W'(10), W'(7));
		send_pair(W'(7), W'(7));
		send_pair(W'(6), W'(9));
		send_pair(W'(2), W'(4));
		send_pair(W'(1), W'(1));
		send_pair(MAX_WORD, MAX_WORD);
		send_pair(MAX_WORD, MAX_WORD - W'(1));
		send_pair(MAX_WORD - W'(1), MAX_WORD);
		send_pair(W'(1), MAX_WORD);
		send_pair(W'(2), MAX_WORD);
		send_pair(MAX_WORD, W'(2));
		send_pair(FIB_LO, FIB_HI);
		send_pair(FIB_HI, FIB_LO);
		send_pair(W'(32'h5555_5555), W'(32'h2AAA_AAAA));
		send_pair(W'(32'h2AAA_AAAA), W'(32'h5555_5555));
		wait_drained();
		hold_off(3);

		sent = 0;
		while (sent < RAND_ITEMS) begin
			burst = $urandom_range(1, 16);
			repeat (burst) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3: begin
						a = W'($urandom);
						m = W'($urandom);
					end
					4, 5: begin
						a = W'($urandom);
						m = W'($urandom_range(1, 1000));
					end
					6: begin
						a = W'($urandom);
						m = MAX_WORD;
					end
					7: begin
						a = W'($urandom_range(0, 64));
						m = W'($urandom);
					end
					8: begin
						a = W'($urandom);
						m = W'($urandom_range(0, 1));
					end
					default: begin
						// Neighbors of the worst-case pair keep the rounds count high.
						a = FIB_LO + W'($urandom_range(0, 3));
						m = FIB_HI - W'($urandom_range(0, 3));
					end
				endcase
				send_pair(a, m);
				sent++;
			end
			if (sent >= RAND_ITEMS / 2 && sent < RAND_ITEMS / 2 + burst) begin
				wait_drained();
			end
			case ($urandom_range(0, 7))
				0, 1, 2: ;
				3, 4, 5: hold_off($urandom_range(1, 8));
				6: hold_off($urandom_range(9, 200));
				default: hold_off($urandom_range(200, 1500));
			endcase
		end

		wait_drained();
		repeat (DRAIN_WAIT) @(negedge clk);
		if (errors == 0 && pending == 0) begin
			$display("modular_inverse: match");
		end else begin
			if (pending != 0) begin
				$error("%0d results never arrived", pending);
			end
			$display("modular_inverse: mismatch");
		end
		$finish;
	end

endmodule
